FILE: rtl/pnm_pkg.sv
// Shared widths, register codes and arithmetic constants of the noise material pixel block.
package pnm_pkg;

  // Channel widths
  localparam int PIX_W      = 12;
  localparam int CH_W       = 8;
  localparam int HT_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Pixel coordinates wrap at this size before use
  localparam int MAX_DIM = 4096;

  // Number of register stages from input word to output word
  localparam int PNM_DEPTH = 13;

  // Configuration register codes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_DARK_MODE    = 2'd0;
  localparam cfg_idx_t REG_ORIGIN_X     = 2'd1;
  localparam cfg_idx_t REG_ORIGIN_Y     = 2'd2;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 2'd3;

  // Multiply-xor mixer constants
  localparam logic [31:0] HASH_KA  = 32'd374761393;
  localparam logic [31:0] HASH_KB  = 32'd668265263;
  localparam logic [31:0] HASH_KS  = 32'd2246822519;
  localparam logic [31:0] HASH_KM  = 32'd1274126177;
  localparam logic [31:0] SALT_CRS = 32'(64'd19 * 64'd2246822519);
  localparam logic [31:0] SALT_FIN = 32'(64'd43 * 64'd2246822519);

  // Reciprocals for truncating division by constants (value * RCP >> shift)
  localparam logic [16:0] RCP18  = 17'd116509;  // shift 21
  localparam logic [18:0] RCP5   = 19'd419431;  // shift 21
  localparam logic [17:0] RCP96  = 18'd174763;  // shift 24
  localparam logic [15:0] RCP100 = 16'd41944;   // shift 22

  // Small divisors on 8-bit magnitudes, shift 16
  localparam logic [12:0] RCP10 = 13'd6554;
  localparam logic [12:0] RCP12 = 13'd5462;
  localparam logic [12:0] RCP14 = 13'd4682;
  localparam logic [12:0] RCP22 = 13'd2979;
  localparam logic [12:0] RCP24 = 13'd2731;
  localparam logic [12:0] RCP26 = 13'd2521;
  localparam logic [12:0] RCP28 = 13'd2341;
  localparam logic [12:0] RCP32 = 13'd2048;
  localparam logic [12:0] RCP36 = 13'd1821;

  // Palette: base, tint and blend weight for light and dark themes
  localparam logic [7:0] LT_BASE_R = 8'd238;
  localparam logic [7:0] LT_BASE_G = 8'd240;
  localparam logic [7:0] LT_BASE_B = 8'd244;
  localparam logic [7:0] LT_TINT_R = 8'd255;
  localparam logic [7:0] LT_TINT_G = 8'd255;
  localparam logic [7:0] LT_TINT_B = 8'd255;
  localparam logic [6:0] LT_WEIGHT = 7'd38;
  localparam logic [7:0] DK_BASE_R = 8'd42;
  localparam logic [7:0] DK_BASE_G = 8'd42;
  localparam logic [7:0] DK_BASE_B = 8'd45;
  localparam logic [7:0] DK_TINT_R = 8'd30;
  localparam logic [7:0] DK_TINT_G = 8'd34;
  localparam logic [7:0] DK_TINT_B = 8'd42;
  localparam logic [6:0] DK_WEIGHT = 7'd34;

  // Saturation bound of the blended numerator (256 * 100)
  localparam logic signed [23:0] BLEND_TOP = 24'sd25600;

  // Truncating quotient of a small magnitude by a reciprocal constant
  function automatic logic [4:0] udiv_small(input logic [7:0] mag, input logic [12:0] rcp);
    logic [20:0] prod;
    prod = 21'(mag) * 21'(rcp);
    return prod[20:16];
  endfunction

  // Reapply the sign taken off before a magnitude division
  function automatic logic signed [5:0] apply_sign(input logic neg, input logic [4:0] q);
    logic signed [5:0] sq;
    sq = $signed({1'b0, q});
    return neg ? -sq : sq;
  endfunction

endpackage

FILE: rtl/pnm_pix_if.sv
// Pixel coordinate channel: valid/ready handshake carrying one pixel position per word.
interface pnm_pix_if import pnm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

FILE: rtl/pnm_rgb_if.sv
// Colour channel: valid/ready handshake carrying one RGB pixel per word.
interface pnm_rgb_if import pnm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: rtl/pnm_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying register index and data.
interface pnm_cfg_if import pnm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/procedural_noise_material_pixel.sv
// Frosted-glass noise pixel generator: a 13-stage pipeline taking one pixel word per clock
// while the output side does not stall; the result word leaves from the stage 12 register.
// The depth is set by the row-scaled vertical ramp, a restoring division by the image height
// spread over nine stages at two quotient bits each, which runs beside the coordinate hash
// (two multiply stages per hash: the argument products, then the final mixer multiply,
// each in its own stage).
// Each stage moves on when it is empty or the stage after it moves, so bubbles close up
// and a full pipeline holds under back-pressure without losing or repeating a word.
// Configuration writes are taken in every cycle and must only be made while no pixel
// is in flight.
module procedural_noise_material_pixel import pnm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pnm_pix_if.sink   in_if,
  pnm_rgb_if.source out_if,
  pnm_cfg_if.sink   cfg_if
);

  localparam int LAST     = PNM_DEPTH - 1;
  localparam int DIV_LAST = 9;

  // Stage payloads
  typedef struct packed {
    logic signed [16:0] gx;
    logic signed [16:0] gy;
  } s0_t;

  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] ay;
    logic        sx;
    logic        sy;
    logic [16:0] as;
    logic        ss;
  } s1_t;

  typedef struct packed {
    logic [11:0] qx18;
    logic [11:0] qy18;
    logic [13:0] qx5;
    logic [13:0] qy5;
    logic [10:0] q96;
    logic [16:0] as;
    logic        sx;
    logic        sy;
    logic        ss;
  } s2_t;

  typedef struct packed {
    logic [31:0]       ac;
    logic [31:0]       bc;
    logic [31:0]       af;
    logic [31:0]       bf;
    logic signed [8:0] diag;
  } s3_t;

  typedef struct packed {
    logic [31:0]       pac;
    logic [31:0]       pbc;
    logic [31:0]       paf;
    logic [31:0]       pbf;
    logic signed [8:0] diag;
  } s4_t;

  typedef struct packed {
    logic [31:0]       tc;
    logic [31:0]       tf;
    logic signed [8:0] diag;
  } s5_t;

  typedef struct packed {
    logic [31:0]       uc;
    logic [31:0]       uf;
    logic signed [8:0] diag;
  } s6_t;

  typedef struct packed {
    logic signed [7:0] coarse;
    logic signed [7:0] fine;
    logic signed [8:0] diag;
  } s7_t;

  typedef struct packed {
    logic [7:0] cm;
    logic [7:0] fm;
    logic [7:0] dm;
    logic       cs;
    logic       fs;
    logic       ds;
  } s8_t;

  typedef struct packed {
    logic signed [5:0] c12;
    logic signed [5:0] c14;
    logic signed [5:0] c10;
    logic signed [5:0] f32;
    logic signed [5:0] f36;
    logic signed [5:0] f28;
    logic signed [5:0] d22;
    logic signed [5:0] d26;
    logic signed [5:0] d24;
  } s9_t;

  typedef struct packed {
    logic signed [17:0] r;
    logic signed [17:0] g;
    logic signed [17:0] b;
  } s10_t;

  typedef struct packed {
    logic signed [23:0] r;
    logic signed [23:0] g;
    logic signed [23:0] b;
  } s11_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } s12_t;

  // Height divider state: partial remainder, numerator bits left, quotient so far
  typedef struct packed {
    logic [12:0] rem;
    logic [17:0] num;
    logic [17:0] quo;
  } div_t;

  // Configuration registers
  logic              dark_r;
  logic signed [15:0] ox_r;
  logic signed [15:0] oy_r;
  logic [HT_W-1:0]   ht_r;

  // Pipeline control
  logic [LAST:0] v_r;
  logic [LAST:0] en;

  s0_t  s0_r,  s0_nxt;
  s1_t  s1_r,  s1_nxt;
  s2_t  s2_r,  s2_nxt;
  s3_t  s3_r,  s3_nxt;
  s4_t  s4_r,  s4_nxt;
  s5_t  s5_r,  s5_nxt;
  s6_t  s6_r,  s6_nxt;
  s7_t  s7_r,  s7_nxt;
  s8_t  s8_r,  s8_nxt;
  s9_t  s9_r,  s9_nxt;
  s10_t s10_r, s10_nxt;
  s11_t s11_r, s11_nxt;
  s12_t s12_r, s12_nxt;

  div_t dv_r [DIV_LAST+1];
  div_t dv0_nxt;

  // Two restoring division steps
  function automatic div_t div2(input div_t d, input logic [12:0] den);
    div_t       o;
    logic [13:0] rem14;
    o = d;
    for (int i = 0; i < 2; i++) begin
      rem14 = {o.rem, o.num[17]};
      o.num = {o.num[16:0], 1'b0};
      if (rem14 >= {1'b0, den}) begin
        rem14 = rem14 - {1'b0, den};
        o.quo = {o.quo[16:0], 1'b1};
      end else begin
        o.quo = {o.quo[16:0], 1'b0};
      end
      o.rem = rem14[12:0];
    end
    return o;
  endfunction

  // Configuration writes, always taken
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_r <= 1'b0;
      ox_r   <= '0;
      oy_r   <= '0;
      ht_r   <= HT_W'(1);
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_if.index)
        REG_DARK_MODE:    dark_r <= cfg_if.data[0];
        REG_ORIGIN_X:     ox_r   <= $signed(cfg_if.data);
        REG_ORIGIN_Y:     oy_r   <= $signed(cfg_if.data);
        REG_IMAGE_HEIGHT: ht_r   <= cfg_if.data[HT_W-1:0];
        default:          ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its word moves on
  always_comb begin
    en[LAST] = !v_r[LAST] || out_if.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_if.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_if.valid;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 0: global coordinates, divider numerator
  always_comb begin
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    px = PIX_W'(32'(in_if.pixel_x) % MAX_DIM);
    py = PIX_W'(32'(in_if.pixel_y) % MAX_DIM);
    s0_nxt.gx   = {ox_r[15], ox_r} + {5'b0, px};
    s0_nxt.gy   = {oy_r[15], oy_r} + {5'b0, py};
    dv0_nxt.rem = '0;
    dv0_nxt.quo = '0;
    dv0_nxt.num = 18'(py) * 18'd22;
  end

  // Stage 1: magnitudes and diagonal sum
  always_comb begin
    logic [16:0] nx;
    logic [16:0] ny;
    logic [17:0] sum;
    logic [17:0] nsum;
    nx   = -s0_r.gx;
    ny   = -s0_r.gy;
    sum  = {s0_r.gx[16], s0_r.gx} + {s0_r.gy[16], s0_r.gy};
    nsum = -sum;
    s1_nxt.sx = s0_r.gx[16];
    s1_nxt.sy = s0_r.gy[16];
    s1_nxt.ax = s0_r.gx[16] ? nx[15:0] : s0_r.gx[15:0];
    s1_nxt.ay = s0_r.gy[16] ? ny[15:0] : s0_r.gy[15:0];
    s1_nxt.ss = sum[17];
    s1_nxt.as = sum[17] ? nsum[16:0] : sum[16:0];
  end

  // Stage 2: cell indices and diagonal quotient by reciprocal multiply
  always_comb begin
    logic [32:0] px18;
    logic [32:0] py18;
    logic [34:0] px5;
    logic [34:0] py5;
    logic [34:0] ps96;
    px18 = 33'(s1_r.ax) * 33'(RCP18);
    py18 = 33'(s1_r.ay) * 33'(RCP18);
    px5  = 35'(s1_r.ax) * 35'(RCP5);
    py5  = 35'(s1_r.ay) * 35'(RCP5);
    ps96 = 35'(s1_r.as) * 35'(RCP96);
    s2_nxt.qx18 = px18[32:21];
    s2_nxt.qy18 = py18[32:21];
    s2_nxt.qx5  = px5[34:21];
    s2_nxt.qy5  = py5[34:21];
    s2_nxt.q96  = ps96[34:24];
    s2_nxt.as   = s1_r.as;
    s2_nxt.sx   = s1_r.sx;
    s2_nxt.sy   = s1_r.sy;
    s2_nxt.ss   = s1_r.ss;
  end

  // Stage 3: signed hash arguments, diagonal ramp
  always_comb begin
    logic [16:0] rem17;
    logic [8:0]  rs;
    logic [8:0]  rd;
    rem17 = s2_r.as - 17'(s2_r.q96) * 17'd96;
    rs    = {2'b0, rem17[6:0]};
    rd    = s2_r.ss ? 9'd0 - rs : rs;
    s3_nxt.ac   = s2_r.sx ? 32'd0 - 32'(s2_r.qx18) : 32'(s2_r.qx18);
    s3_nxt.bc   = s2_r.sy ? 32'd0 - 32'(s2_r.qy18) : 32'(s2_r.qy18);
    s3_nxt.af   = s2_r.sx ? 32'd0 - 32'(s2_r.qx5)  : 32'(s2_r.qx5);
    s3_nxt.bf   = s2_r.sy ? 32'd0 - 32'(s2_r.qy5)  : 32'(s2_r.qy5);
    s3_nxt.diag = $signed(rd - 9'd48);
  end

  // Stage 4: mixer input products
  always_comb begin
    s4_nxt.pac  = s3_r.ac * HASH_KA;
    s4_nxt.pbc  = s3_r.bc * HASH_KB;
    s4_nxt.paf  = s3_r.af * HASH_KA;
    s4_nxt.pbf  = s3_r.bf * HASH_KB;
    s4_nxt.diag = s3_r.diag;
  end

  // Stage 5: sum with salt, first xor-shift
  always_comb begin
    logic [31:0] hc;
    logic [31:0] hf;
    hc = s4_r.pac + s4_r.pbc + SALT_CRS;
    hf = s4_r.paf + s4_r.pbf + SALT_FIN;
    s5_nxt.tc   = hc ^ (hc >> 13);
    s5_nxt.tf   = hf ^ (hf >> 13);
    s5_nxt.diag = s4_r.diag;
  end

  // Stage 6: mixer final multiply
  always_comb begin
    s6_nxt.uc   = s5_r.tc * HASH_KM;
    s6_nxt.uf   = s5_r.tf * HASH_KM;
    s6_nxt.diag = s5_r.diag;
  end

  // Stage 7: low byte of the final xor-shift, centred on zero
  always_comb begin
    logic [7:0] cb;
    logic [7:0] fb;
    cb = s6_r.uc[7:0] ^ s6_r.uc[23:16];
    fb = s6_r.uf[7:0] ^ s6_r.uf[23:16];
    s7_nxt.coarse = $signed({~cb[7], cb[6:0]});
    s7_nxt.fine   = $signed({~fb[7], fb[6:0]});
    s7_nxt.diag   = s6_r.diag;
  end

  // Stage 8: signs and magnitudes for truncating division
  always_comb begin
    logic [7:0] nc;
    logic [7:0] nf;
    logic [8:0] nd;
    nc = -s7_r.coarse;
    nf = -s7_r.fine;
    nd = -s7_r.diag;
    s8_nxt.cs = s7_r.coarse[7];
    s8_nxt.fs = s7_r.fine[7];
    s8_nxt.ds = s7_r.diag[8];
    s8_nxt.cm = s7_r.coarse[7] ? nc : s7_r.coarse;
    s8_nxt.fm = s7_r.fine[7]   ? nf : s7_r.fine;
    s8_nxt.dm = s7_r.diag[8]   ? nd[7:0] : s7_r.diag[7:0];
  end

  // Stage 9: per-channel weighted terms
  always_comb begin
    s9_nxt.c12 = apply_sign(s8_r.cs, udiv_small(s8_r.cm, RCP12));
    s9_nxt.c14 = apply_sign(s8_r.cs, udiv_small(s8_r.cm, RCP14));
    s9_nxt.c10 = apply_sign(s8_r.cs, udiv_small(s8_r.cm, RCP10));
    s9_nxt.f32 = apply_sign(s8_r.fs, udiv_small(s8_r.fm, RCP32));
    s9_nxt.f36 = apply_sign(s8_r.fs, udiv_small(s8_r.fm, RCP36));
    s9_nxt.f28 = apply_sign(s8_r.fs, udiv_small(s8_r.fm, RCP28));
    s9_nxt.d22 = apply_sign(s8_r.ds, udiv_small(s8_r.dm, RCP22));
    s9_nxt.d26 = apply_sign(s8_r.ds, udiv_small(s8_r.dm, RCP26));
    s9_nxt.d24 = apply_sign(s8_r.ds, udiv_small(s8_r.dm, RCP24));
  end

  // Stage 10: base colour plus noise, diagonal and vertical ramps
  always_comb begin
    logic [17:0] vert;
    logic [7:0]  base_r;
    logic [7:0]  base_g;
    logic [7:0]  base_b;
    vert   = (ht_r > HT_W'(1)) ? dv_r[DIV_LAST].quo - 18'd11 : 18'd0;
    base_r = dark_r ? DK_BASE_R : LT_BASE_R;
    base_g = dark_r ? DK_BASE_G : LT_BASE_G;
    base_b = dark_r ? DK_BASE_B : LT_BASE_B;
    s10_nxt.r = $signed(18'(base_r) + 18'(s9_r.c12) + 18'(s9_r.f32) + 18'(s9_r.d22) + vert);
    s10_nxt.g = $signed(18'(base_g) + 18'(s9_r.c14) + 18'(s9_r.f36) + 18'(s9_r.d26) + vert);
    s10_nxt.b = $signed(18'(base_b) + 18'(s9_r.c10) + 18'(s9_r.f28) - 18'(s9_r.d24) + vert);
  end

  // Stage 11: blend numerator toward the tint
  always_comb begin
    logic [6:0] w;
    logic [6:0] wc;
    logic [7:0] tint_r;
    logic [7:0] tint_g;
    logic [7:0] tint_b;
    w      = dark_r ? DK_WEIGHT : LT_WEIGHT;
    wc     = 7'd100 - w;
    tint_r = dark_r ? DK_TINT_R : LT_TINT_R;
    tint_g = dark_r ? DK_TINT_G : LT_TINT_G;
    tint_b = dark_r ? DK_TINT_B : LT_TINT_B;
    s11_nxt.r = $signed(24'(s10_r.r) * 24'(wc) + 24'(tint_r) * 24'(w));
    s11_nxt.g = $signed(24'(s10_r.g) * 24'(wc) + 24'(tint_g) * 24'(w));
    s11_nxt.b = $signed(24'(s10_r.b) * 24'(wc) + 24'(tint_b) * 24'(w));
  end

  // Stage 12: divide by 100 and saturate to a byte
  function automatic logic [7:0] blend_out(input logic signed [23:0] n);
    logic [30:0] prod;
    prod = 31'(n[14:0]) * 31'(RCP100);
    if (n[23]) begin
      return 8'd0;
    end else if (n >= BLEND_TOP) begin
      return 8'hff;
    end
    return prod[29:22];
  endfunction

  always_comb begin
    s12_nxt.red   = blend_out(s11_r.r);
    s12_nxt.green = blend_out(s11_r.g);
    s12_nxt.blue  = blend_out(s11_r.b);
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en[0])  s0_r  <= s0_nxt;
    if (en[1])  s1_r  <= s1_nxt;
    if (en[2])  s2_r  <= s2_nxt;
    if (en[3])  s3_r  <= s3_nxt;
    if (en[4])  s4_r  <= s4_nxt;
    if (en[5])  s5_r  <= s5_nxt;
    if (en[6])  s6_r  <= s6_nxt;
    if (en[7])  s7_r  <= s7_nxt;
    if (en[8])  s8_r  <= s8_nxt;
    if (en[9])  s9_r  <= s9_nxt;
    if (en[10]) s10_r <= s10_nxt;
    if (en[11]) s11_r <= s11_nxt;
    if (en[12]) s12_r <= s12_nxt;
  end

  // Height divider, two quotient bits per stage alongside the hash path
  always_ff @(posedge clk) begin
    if (en[0]) begin
      dv_r[0] <= dv0_nxt;
    end
    for (int k = 1; k <= DIV_LAST; k++) begin
      if (en[k]) begin
        dv_r[k] <= div2(dv_r[k-1], ht_r);
      end
    end
  end

  // Output register
  assign out_if.valid = v_r[LAST];
  assign out_if.red   = s12_r.red;
  assign out_if.green = s12_r.green;
  assign out_if.blue  = s12_r.blue;

endmodule

FILE: rtl/pnm_checker.sv
// Port-level checker for the noise material pixel block and its bind.
module pnm_checker import pnm_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [CH_W-1:0] out_red,
  input logic [CH_W-1:0] out_green,
  input logic [CH_W-1:0] out_blue,
  input logic            cfg_valid,
  input logic            cfg_ready
);

  localparam int OCC_W = $clog2(PNM_DEPTH + 1) + 1;

  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;

  // Words in flight between the two sides
  always_comb begin
    occ_nxt = occ_r;
    if (in_valid && in_ready) occ_nxt = occ_nxt + OCC_W'(1);
    if (out_valid && out_ready) occ_nxt = occ_nxt - OCC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue))
    else $error("result word changed while stalled");

  // Reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // With the output draining every stage moves, so a new word is always taken
  a_flow: assert property (@(posedge clk) disable iff (!rst_n) out_ready |-> in_ready)
    else $error("input stalled while output ready");

  // Never more words in flight than stages, and no result from an empty pipeline
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(PNM_DEPTH) && (!out_valid || occ_r != '0))
    else $error("pipeline occupancy out of range");

  // Configuration writes are never held off
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind procedural_noise_material_pixel pnm_checker u_pnm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_red   (out_if.red),
  .out_green (out_if.green),
  .out_blue  (out_if.blue),
  .cfg_valid (cfg_if.valid),
  .cfg_ready (cfg_if.ready)
);

FILE: test/tb.sv
// Testbench for the frosted-glass noise pixel generator against a local colour predictor.
module tb;
  import pnm_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_PHASE   = 10;
  localparam int HOLD_CYCLES  = 150;
  localparam int N_PHASES     = 13;
  localparam int RAND_PER_PHS = 166;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
  } pix_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pnm_pix_if in_if();
  pnm_rgb_if out_if();
  pnm_cfg_if cfg_if();

  procedural_noise_material_pixel DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // Local copy of the register file
  logic        cur_dark = 1'b0;
  int          cur_ox = 0;
  int          cur_oy = 0;
  logic [12:0] cur_h = 13'd1;

  pix_t pix_q[$];
  rgb_t colour_q[$];
  logic pix_taken = 1'b0;
  int   n_pushed = 0;
  int   n_taken = 0;
  int   n_errors = 0;
  int   phase = 0;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   hold_cnt = 0;
  int   cycles = 0;

  // Clock
  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // 32-bit multiply-xor cell hash
  function automatic logic [31:0] cell_hash(input int a, input int b, input logic [31:0] salt);
    logic [31:0] ua;
    logic [31:0] ub;
    logic [31:0] h;
    ua = a;
    ub = b;
    h = ua * 32'd374761393 + ub * 32'd668265263 + salt * 32'd2246822519;
    h = (h ^ (h >> 13)) * 32'd1274126177;
    return h ^ (h >> 16);
  endfunction

  function automatic logic [7:0] clamp_byte(input int v);
    if (v < 0) begin
      return 8'd0;
    end
    if (v > 255) begin
      return 8'd255;
    end
    return 8'(v);
  endfunction

  // Expected colour of one pixel under the current register settings
  function automatic rgb_t frost_colour(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
    int gx, gy, crs, fin, dg, vt;
    int w, br, bg, bb, tr, tg, tb_;
    int r, g, b;
    logic [31:0] h;
    rgb_t c;
    gx = cur_ox + int'(px);
    gy = cur_oy + int'(py);
    h = cell_hash(gx / 18, gy / 18, 32'd19);
    crs = int'(h[7:0]) - 128;
    h = cell_hash(gx / 5, gy / 5, 32'd43);
    fin = int'(h[7:0]) - 128;
    dg = ((gx + gy) % 96) - 48;
    // heights of zero and one give a flat vertical ramp
    vt = 0;
    if (cur_h > 13'd1) begin
      vt = (int'(py) * 22) / int'(cur_h) - 11;
    end
    if (cur_dark) begin
      w = 34; br = 42; bg = 42; bb = 45; tr = 30; tg = 34; tb_ = 42;
    end else begin
      w = 38; br = 238; bg = 240; bb = 244; tr = 255; tg = 255; tb_ = 255;
    end
    r = br + crs / 12 + fin / 32 + dg / 22 + vt;
    g = bg + crs / 14 + fin / 36 + dg / 26 + vt;
    b = bb + crs / 10 + fin / 28 - dg / 24 + vt;
    r = (r * (100 - w) + tr * w) / 100;
    g = (g * (100 - w) + tg * w) / 100;
    b = (b * (100 - w) + tb_ * w) / 100;
    c.red = clamp_byte(r);
    c.green = clamp_byte(g);
    c.blue = clamp_byte(b);
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d want %0d at cycle %0d", what, got, want, cycles);
    n_errors++;
  endtask

  task automatic queue_pixel(input int x, input int y);
    pix_t p;
    p.x = PIX_W'(x);
    p.y = PIX_W'(y);
    pix_q.push_back(p);
    n_pushed++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  // All four registers, written back to back
  task automatic configure(input logic [15:0] d_dark, input logic [15:0] d_ox,
                           input logic [15:0] d_oy, input logic [15:0] d_h);
    write_reg(REG_DARK_MODE, d_dark);
    write_reg(REG_ORIGIN_X, d_ox);
    write_reg(REG_ORIGIN_Y, d_oy);
    write_reg(REG_IMAGE_HEIGHT, d_h);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Pixel driver: holds a word until taken, gaps at random
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !pix_taken) begin
      // word still waiting
    end else if (pix_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
      pix_t p;
      p = pix_q.pop_front();
      in_if.valid <= 1'b1;
      in_if.pixel_x <= p.x;
      in_if.pixel_y <= p.y;
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // Colour receiver: random stalls, plus one long hold-off in the pressure phase
  always @(negedge clk) begin
    if (phase == HOLD_PHASE && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Monitor: check results, predict accepted pixels, track register writes
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (colour_q.size() == 0) begin
          report_mismatch("colour word with nothing expected", out_if.red, -1);
        end else begin
          want = colour_q.pop_front();
          if (out_if.red !== want.red) report_mismatch("red", out_if.red, want.red);
          if (out_if.green !== want.green) report_mismatch("green", out_if.green, want.green);
          if (out_if.blue !== want.blue) report_mismatch("blue", out_if.blue, want.blue);
        end
      end
      if (in_if.valid && in_if.ready) begin
        colour_q.push_back(frost_colour(in_if.pixel_x, in_if.pixel_y));
        n_taken++;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_DARK_MODE: begin
            cur_dark <= cfg_if.data[0];
          end
          REG_ORIGIN_X: begin
            cur_ox <= int'($signed(cfg_if.data));
          end
          REG_ORIGIN_Y: begin
            cur_oy <= int'($signed(cfg_if.data));
          end
          REG_IMAGE_HEIGHT: begin
            cur_h <= cfg_if.data[12:0];
          end
          default: begin
          end
        endcase
      end
    end
    pix_taken <= in_if.valid && in_if.ready;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    int p, k, x, y, hsel, hmax;
    logic [15:0] d_ox, d_oy;
    in_if.valid = 1'b0;
    in_if.pixel_x = '0;
    in_if.pixel_y = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_DARK_MODE;
    cfg_if.data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (p = 0; p < N_PHASES; p++) begin
      hsel = 1;
      // registers only change between phases, with nothing in flight
      case (p)
        0: begin
          // reset values: light, origin at zero, height one
        end
        1: begin
          configure(16'hFFFF, 16'h8000, 16'h8000, 16'h0000);
          hsel = 0;
        end
        2: begin
          configure(16'h0000, 16'h7FFF, 16'h7FFF, 16'd4096);
          hsel = 4096;
        end
        3: begin
          configure(16'h0001, 16'hFFFF, -16'sd100, 16'd2);
          hsel = 2;
        end
        4: begin
          configure(16'hFFFE, -16'sd18, 16'd17, 16'hFFFF);
          hsel = 8191;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: d_ox = 16'(-32768 + $urandom_range(0, 300));
            1: d_ox = 16'(32767 - $urandom_range(0, 300));
            2: d_ox = 16'($signed($urandom_range(0, 600)) - 300);
            default: d_ox = 16'($urandom);
          endcase
          case ($urandom_range(0, 3))
            0: d_oy = 16'(-32768 + $urandom_range(0, 300));
            1: d_oy = 16'(32767 - $urandom_range(0, 300));
            2: d_oy = 16'($signed($urandom_range(0, 600)) - 300);
            default: d_oy = 16'($urandom);
          endcase
          case ($urandom_range(0, 4))
            0: hsel = $urandom_range(0, 1);
            1: hsel = 4096;
            2: hsel = $urandom_range(2, 40);
            3: hsel = $urandom_range(2, 4096);
            default: hsel = $urandom_range(0, 8191);
          endcase
          configure({15'($urandom), 1'($urandom_range(0, 1))}, d_ox, d_oy,
                    {3'($urandom), 13'(hsel)});
        end
      endcase

      @(posedge clk);
      phase = p;
      // idling: sender lighter first, then receiver lighter, then none
      if (p < 5) begin
        send_idle = 34;
        recv_idle = 46;
      end else if (p < 9) begin
        send_idle = 46;
        recv_idle = 34;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end

      case (p)
        0: begin
          queue_pixel(0, 0);
          queue_pixel(4095, 4095);
          queue_pixel(0, 4095);
          queue_pixel(4095, 0);
          queue_pixel(17, 18);
        end
        1: begin
          // global coordinates deep in the negative range
          queue_pixel(0, 0);
          queue_pixel(4095, 4095);
          queue_pixel(5, 4095);
          queue_pixel(4095, 17);
        end
        2: begin
          queue_pixel(0, 0);
          queue_pixel(4095, 4095);
          queue_pixel(4095, 0);
          queue_pixel(0, 4095);
        end
        3: begin
          // rows past the image height, small negative origin
          queue_pixel(0, 0);
          queue_pixel(1, 1);
          queue_pixel(3, 2);
          queue_pixel(100, 4095);
          queue_pixel(4095, 1);
        end
        4: begin
          queue_pixel(0, 0);
          queue_pixel(18, 0);
          queue_pixel(4095, 4095);
        end
        default: begin
          hmax = (hsel > 4096) ? 4096 : hsel;
          for (k = 0; k < RAND_PER_PHS; k++) begin
            if ($urandom_range(0, 7) == 0) x = $urandom_range(0, 1) ? 4095 : 0;
            else x = $urandom_range(0, 4095);
            if (hsel > 1 && $urandom_range(0, 2) != 0) y = $urandom_range(0, hmax - 1);
            else if ($urandom_range(0, 7) == 0) y = $urandom_range(0, 1) ? 4095 : 0;
            else y = $urandom_range(0, 4095);
            queue_pixel(x, y);
          end
        end
      endcase

      do @(negedge clk); while (n_taken != n_pushed || colour_q.size() != 0);
    end

    // drain: nothing more should turn up
    repeat (PNM_DEPTH * 3) @(negedge clk);
    if (colour_q.size() != 0) begin
      report_mismatch("colour words never delivered", 0, colour_q.size());
    end
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
